/* hdl/pcl_pkg.sv */
`default_nettype none

package pcl_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int DATA_W       = 32;
	localparam int FUNC_W       = 3;
	localparam int POS_W        = 7;
	localparam int TOTAL_W      = 7;
	localparam int STATUS_W     = 2;

	typedef enum logic [FUNC_W-1:0] {
		FN_INS_FRONT = 3'd0,
		FN_INS_BACK  = 3'd1,
		FN_INS_POS   = 3'd2,
		FN_DEL_FRONT = 3'd3,
		FN_DEL_BACK  = 3'd4,
		FN_DEL_POS   = 3'd5,
		FN_READOUT   = 3'd6
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT,
		S_PUT,
		S_READ,
		S_RESULT
	} state_t;

	// one result word handed from the sequencer to the output register
	typedef struct packed {
		logic                     load;
		status_t                  status;
		logic [TOTAL_W-1:0]       total;
		logic signed [DATA_W-1:0] element;
		logic                     last;
	} res_t;

endpackage

`default_nettype wire

/* hdl/pcl_ram.sv */
`default_nettype none

module pcl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* hdl/pcl_ctrl.sv */
`default_nettype none

module pcl_ctrl import pcl_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [FUNC_W-1:0]             func,
	input  logic signed [DATA_W-1:0]      value,
	input  logic [POS_W-1:0]              position,
	input  logic                          out_free,
	output res_t                          res,
	output logic                          ram_we,
	output logic [$clog2(CAPACITY)-1:0]   ram_waddr,
	output logic [DATA_W-1:0]             ram_wdata,
	output logic                          ram_re,
	output logic [$clog2(CAPACITY)-1:0]   ram_raddr,
	input  logic [DATA_W-1:0]             ram_rdata
);

	localparam int OW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = ((OW > POS_W) ? OW : POS_W) + 1;

	state_t               state_q, state_d;
	logic [OW-1:0]        occ_q;
	logic [AW-1:0]        idx_q;
	logic [AW-1:0]        c_q;
	logic [AW-1:0]        w_q;
	logic [OW-1:0]        n_q;
	logic                 pend_q;
	logic                 up_q;
	status_t              st_q;
	logic [DATA_W-1:0]    val_q;

	logic                 accept;
	logic [CW-1:0]        occ_w;
	logic [CW-1:0]        pos_w;
	logic                 full;
	logic                 empty;
	state_t               dec_state;
	status_t              dec_status;
	logic [OW-1:0]        dec_idx;
	logic                 dec_up;
	logic                 load;
	logic                 last_e;

	assign accept = in_valid && (state_q == S_IDLE);
	assign occ_w  = CW'(occ_q);
	assign pos_w  = CW'(position);
	assign full   = (occ_w == CW'(CAPACITY));
	assign empty  = (occ_q == '0);
	assign last_e = (n_q == OW'(1));
	assign load   = (state_q == S_READ) && pend_q && out_free;

	// request decode and range checks
	always_comb begin
		dec_state  = S_RESULT;
		dec_status = ST_OK;
		dec_idx    = '0;
		dec_up     = 1'b1;
		case (func)
			FN_INS_FRONT, FN_INS_BACK: begin
				if (full) begin
					dec_status = ST_FULL;
				end else begin
					dec_state = S_SHIFT;
					dec_idx   = (func == FN_INS_FRONT) ? '0 : occ_q;
				end
			end
			FN_INS_POS: begin
				if (position == '0 || pos_w > occ_w + CW'(1)) begin
					dec_status = ST_BADPOS;
				end else if (full) begin
					dec_status = ST_FULL;
				end else begin
					dec_state = S_SHIFT;
					dec_idx   = OW'(pos_w - CW'(1));
				end
			end
			FN_DEL_FRONT, FN_DEL_BACK: begin
				dec_up = 1'b0;
				if (empty) begin
					dec_status = ST_EMPTY;
				end else begin
					dec_state = S_SHIFT;
					dec_idx   = (func == FN_DEL_FRONT) ? '0 : occ_q - OW'(1);
				end
			end
			FN_DEL_POS: begin
				dec_up = 1'b0;
				if (position == '0 || pos_w > occ_w) begin
					dec_status = ST_BADPOS;
				end else begin
					dec_state = S_SHIFT;
					dec_idx   = OW'(pos_w - CW'(1));
				end
			end
			FN_READOUT: begin
				if (empty) begin
					dec_status = ST_EMPTY;
				end else begin
					dec_state = S_READ;
				end
			end
			default: begin
				dec_status = ST_OK;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = dec_state;
				end
			end
			S_SHIFT: begin
				if (n_q == '0) begin
					state_d = up_q ? S_PUT : S_RESULT;
				end
			end
			S_PUT: begin
				state_d = S_RESULT;
			end
			S_READ: begin
				if (load && last_e) begin
					state_d = S_IDLE;
				end
			end
			S_RESULT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall    = (state_q != S_IDLE);
		ram_we      = 1'b0;
		ram_waddr   = w_q;
		ram_wdata   = ram_rdata;
		ram_re      = 1'b0;
		ram_raddr   = c_q;
		res.load    = 1'b0;
		res.status  = st_q;
		res.total   = TOTAL_W'(occ_q);
		res.element = '0;
		res.last    = 1'b1;
		case (state_q)
			S_SHIFT: begin
				// read one slot ahead, write the word read last cycle
				ram_we = pend_q;
				ram_re = (n_q != '0);
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = val_q;
			end
			S_READ: begin
				ram_re      = !pend_q || (load && !last_e);
				res.load    = load;
				res.status  = ST_OK;
				res.element = ram_rdata;
				res.last    = last_e;
			end
			S_RESULT: begin
				res.load = out_free;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q   <= '0;
			pend_q  <= 1'b0;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						pend_q <= 1'b0;
						if (dec_state == S_READ) begin
							n_q <= occ_q;
						end else if (dec_up) begin
							n_q <= occ_q - dec_idx;
						end else begin
							n_q <= occ_q - dec_idx - OW'(1);
						end
					end
				end
				S_SHIFT: begin
					if (n_q != '0) begin
						n_q    <= n_q - OW'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!up_q) begin
							occ_q <= occ_q - OW'(1);
						end
					end
				end
				S_PUT: begin
					occ_q <= occ_q + OW'(1);
				end
				S_READ: begin
					if (ram_re) begin
						pend_q <= 1'b1;
					end
					if (load) begin
						n_q <= n_q - OW'(1);
						if (last_e) begin
							pend_q <= 1'b0;
						end
					end
				end
				default: begin
					pend_q <= pend_q;
				end
			endcase
		end
	end

	// address stepping and request payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					st_q  <= dec_status;
					val_q <= value;
					up_q  <= dec_up;
					idx_q <= AW'(dec_idx);
					if (dec_state == S_READ) begin
						c_q <= '0;
					end else if (dec_up) begin
						c_q <= AW'(occ_q - OW'(1));
					end else begin
						c_q <= AW'(dec_idx + OW'(1));
					end
				end
			end
			S_SHIFT: begin
				if (n_q != '0) begin
					w_q <= up_q ? c_q + AW'(1) : c_q - AW'(1);
					c_q <= up_q ? c_q - AW'(1) : c_q + AW'(1);
				end
			end
			S_READ: begin
				if (ram_re) begin
					c_q <= c_q + AW'(1);
				end
			end
			default: begin
				c_q <= c_q;
			end
		endcase
	end

endmodule

`default_nettype wire

/* hdl/positional_circular_list.sv */
// channel  | handshake            | payload
// ---------+----------------------+--------------------------------------------
// in       | in_valid / in_stall  | func, value, position
// out      | out_valid / out_stall| status, entry_total, element, last
//
// insert and delete move every entry behind the position by one slot, through
// the single read/write port pair of the ram. readout: one word per cycle once
// the first read returns, while out_stall is low. rejected or empty requests go
// straight to the result word. in_stall is high until the last word of a request
// is in the output register; out_stall holds that register.
// arst_n clears the entry count and the sequencer; list contents are not cleared.
`default_nettype none

module positional_circular_list import pcl_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [FUNC_W-1:0]        func,
	input  logic signed [DATA_W-1:0] value,
	input  logic [POS_W-1:0]         position,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [STATUS_W-1:0]      status,
	output logic [TOTAL_W-1:0]       entry_total,
	output logic signed [DATA_W-1:0] element,
	output logic                     last
);

	localparam int AW = $clog2(CAPACITY);

	res_t                     res;
	logic                     out_free;
	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic [DATA_W-1:0]        ram_wdata;
	logic                     ram_re;
	logic [AW-1:0]            ram_raddr;
	logic [DATA_W-1:0]        ram_rdata;

	logic                     out_valid_q;
	status_t                  status_q;
	logic [TOTAL_W-1:0]       total_q;
	logic signed [DATA_W-1:0] element_q;
	logic                     last_q;

	assign out_free = !out_valid_q || !out_stall;

	pcl_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.value     (value),
		.position  (position),
		.out_free  (out_free),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	pcl_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			status_q  <= res.status;
			total_q   <= res.total;
			element_q <= res.element;
			last_q    <= res.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_total = total_q;
	assign element     = element_q;
	assign last        = last_q;

endmodule

`default_nettype wire

/* hdl/pcl_chk.sv */
`default_nettype none

module pcl_chk import pcl_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [STATUS_W-1:0]      status,
	input logic [TOTAL_W-1:0]       entry_total,
	input logic signed [DATA_W-1:0] element,
	input logic                     last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(entry_total)
			&& $stable(element) && $stable(last))
		else $error("stalled word changed");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> last && element == '0)
		else $error("error result is not a single zero word");

	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(entry_total) <= CAPACITY)
		else $error("entry count above capacity");

	a_readout_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("request taken during readout");

	a_readout_stream: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("gap in readout stream");

endmodule

bind positional_circular_list pcl_chk #(.CAPACITY(CAPACITY)) u_pcl_chk (.*);

`default_nettype wire
